[rtl/lpht_pkg.sv]
// Shared types, constants and codes for the linear-probe hash table.
`default_nettype none
package lpht_pkg;
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned HASH_W = 32;
  localparam logic [CNT_W-1:0] LENGTH_AT_RESET = CNT_W'(17);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [2:0] REG_TABLE_LENGTH = 3'd0;

  typedef struct packed {
    logic [1:0]        action;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] key_hash;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] live_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       state;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_word_t;

  localparam int unsigned WORD_W = $bits(slot_word_t);
endpackage
`default_nettype wire

[rtl/lpht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/lpht_mod.sv]
// Restoring remainder unit: hash modulo table length, one quotient bit per cycle.
`default_nettype none
module lpht_mod (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [lpht_pkg::HASH_W-1:0] hash,
  input  wire logic [lpht_pkg::CNT_W-1:0]  len,
  output logic                             done,
  output logic      [lpht_pkg::IDX_W-1:0]  rem
);
  logic                             busy;
  logic [$clog2(lpht_pkg::HASH_W)-1:0] cnt;
  logic [lpht_pkg::HASH_W-1:0]      dividend;
  logic [lpht_pkg::CNT_W-1:0]       trial;

  // The running remainder stays below len, so it fits the slot index width.
  assign trial = {rem, dividend[lpht_pkg::HASH_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dividend <= hash;
      end else if (busy) begin
        if (trial >= len) begin
          rem <= lpht_pkg::IDX_W'(trial - len);
        end else begin
          rem <= trial[lpht_pkg::IDX_W-1:0];
        end
        dividend <= dividend << 1;
        cnt      <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/linear_probe_hash_table_core.sv]
// Top level of the open-addressing hash table with linear probing and tombstones.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | lpht_pkg::req_t
//  rsp     | out       | rsp_valid/rsp_stall | lpht_pkg::rsp_t
//  apb     | in/out    | psel/penable/pready | table_length at address 0
//
// Insert, lookup and remove first compute the hash remainder in the iterative
// divider, then read and check each probed slot in turn (states S_RD and S_CHK).
// Clear sweeps all 1024 slots, one per cycle.
// After reset the same sweep runs before any transaction is taken.
// A new request is taken while a finished response still waits in the output
// register; a stalled response holds until taken.
`default_nettype none
module linear_probe_hash_table_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire lpht_pkg::req_t              req,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output lpht_pkg::rsp_t                   rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_MOD, S_RD, S_CHK, S_DONE} state_t;

  state_t                        st;
  lpht_pkg::req_t                item;
  lpht_pkg::rsp_t                res;
  logic [lpht_pkg::CNT_W-1:0]    table_length;
  logic [lpht_pkg::CNT_W-1:0]    len_eff;
  logic [lpht_pkg::CNT_W-1:0]    count;
  logic [lpht_pkg::CNT_W-1:0]    n;
  logic [lpht_pkg::IDX_W-1:0]    idx;
  logic [lpht_pkg::IDX_W-1:0]    tomb;
  logic                          have_tomb;
  logic [lpht_pkg::IDX_W-1:0]    clr_addr;
  logic                          clr_reply;
  logic                          mod_start;
  logic                          mod_done;
  logic [lpht_pkg::IDX_W-1:0]    mod_rem;

  logic                          ram_we;
  logic [lpht_pkg::IDX_W-1:0]    ram_waddr;
  lpht_pkg::slot_word_t          ram_wdata;
  logic [lpht_pkg::WORD_W-1:0]   ram_rdata;
  lpht_pkg::slot_word_t          word;

  logic                          is_insert;
  logic                          is_remove;
  logic                          hit;
  logic                          last;
  logic                          tomb_ok;
  logic [lpht_pkg::IDX_W-1:0]    tomb_at;
  logic [lpht_pkg::CNT_W-1:0]    idx_inc;
  logic                          accept;
  logic                          cfg_wr;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr == lpht_pkg::REG_TABLE_LENGTH);
  assign prdata    = (paddr == lpht_pkg::REG_TABLE_LENGTH) ? 32'(table_length) : 32'd0;
  assign req_stall = (st != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign mod_start = accept && (req.action != lpht_pkg::ACT_CLEAR);

  assign word      = lpht_pkg::slot_word_t'(ram_rdata);
  assign is_insert = (item.action == lpht_pkg::ACT_INSERT);
  assign is_remove = (item.action == lpht_pkg::ACT_REMOVE);
  assign hit       = (word.state == lpht_pkg::SLOT_LIVE) && (word.key == item.key);
  assign last      = ((n + 1'b1) == len_eff);
  assign tomb_ok   = have_tomb || (word.state == lpht_pkg::SLOT_TOMB);
  assign tomb_at   = have_tomb ? tomb : idx;
  assign idx_inc   = {1'b0, idx} + 1'b1;

  lpht_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .hash  (req.key_hash),
    .len   (len_eff),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  lpht_ram #(
    .WIDTH (lpht_pkg::WORD_W),
    .DEPTH (lpht_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = word;
    if (st == S_CLR) begin
      ram_we          = 1'b1;
      ram_waddr       = clr_addr;
      ram_wdata.state = lpht_pkg::SLOT_EMPTY;
    end else if (st == S_CHK) begin
      if (is_insert && !hit && (word.state == lpht_pkg::SLOT_EMPTY || (last && tomb_ok))) begin
        ram_we          = 1'b1;
        ram_waddr       = tomb_at;
        ram_wdata.state = lpht_pkg::SLOT_LIVE;
        ram_wdata.key   = item.key;
        ram_wdata.value = item.value;
      end else if (is_remove && hit) begin
        ram_we          = 1'b1;
        ram_wdata.state = lpht_pkg::SLOT_TOMB;
      end
    end
  end

  // The low CNT_W bits of a written length are clamped to 1..DEPTH in len_eff; table_length keeps them as written.
  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= lpht_pkg::LENGTH_AT_RESET;
      len_eff      <= lpht_pkg::LENGTH_AT_RESET;
    end else if (cfg_wr) begin
      table_length <= pwdata[lpht_pkg::CNT_W-1:0];
      if (pwdata[lpht_pkg::CNT_W-1:0] == '0) begin
        len_eff <= lpht_pkg::CNT_W'(1);
      end else if (pwdata[lpht_pkg::CNT_W-1:0] > lpht_pkg::CNT_W'(lpht_pkg::DEPTH)) begin
        len_eff <= lpht_pkg::CNT_W'(lpht_pkg::DEPTH);
      end else begin
        len_eff <= pwdata[lpht_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
      have_tomb <= 1'b0;
    end else begin
      if (st == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (st)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == lpht_pkg::IDX_W'(lpht_pkg::DEPTH - 1)) begin
            count <= '0;
            if (clr_reply) begin
              res <= '{status: lpht_pkg::ST_OK, found_value: '0, slot: '0, live_count: '0};
              st  <= S_DONE;
            end else begin
              st <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (accept) begin
            item      <= req;
            have_tomb <= 1'b0;
            n         <= '0;
            if (req.action == lpht_pkg::ACT_CLEAR) begin
              clr_addr  <= '0;
              clr_reply <= 1'b1;
              st        <= S_CLR;
            end else begin
              st <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            idx <= mod_rem;
            st  <= S_RD;
          end
        end
        S_RD: begin
          st <= S_CHK;
        end
        S_CHK: begin
          priority if (hit) begin
            if (is_insert) begin
              res <= '{status: lpht_pkg::ST_PRESENT, found_value: '0, slot: idx,
                       live_count: '0};
            end else begin
              res <= '{status: lpht_pkg::ST_OK, found_value: word.value, slot: idx,
                       live_count: '0};
              if (is_remove && count != '0) begin
                count <= count - 1'b1;
              end
            end
            st <= S_DONE;
          end else if (word.state == lpht_pkg::SLOT_EMPTY || last) begin
            if (is_insert && (word.state == lpht_pkg::SLOT_EMPTY || tomb_ok)) begin
              res   <= '{status: lpht_pkg::ST_OK, found_value: '0, slot: tomb_at,
                         live_count: '0};
              count <= count + 1'b1;
            end else if (is_insert) begin
              res <= '{status: lpht_pkg::ST_FULL, found_value: '0, slot: '0, live_count: '0};
            end else begin
              res <= '{status: lpht_pkg::ST_MISSING, found_value: '0, slot: '0,
                       live_count: '0};
            end
            st <= S_DONE;
          end else begin
            if (word.state == lpht_pkg::SLOT_TOMB && !have_tomb) begin
              have_tomb <= 1'b1;
              tomb      <= idx;
            end
            idx <= (idx_inc == len_eff) ? '0 : idx_inc[lpht_pkg::IDX_W-1:0];
            n   <= n + 1'b1;
            st  <= S_RD;
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= '{status: res.status, found_value: res.found_value,
                           slot: res.slot, live_count: count};
            clr_reply <= 1'b0;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/lpht_chk.sv]
// Port-level checker for the hash table core, bound to the top level.
`default_nettype none
module lpht_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire lpht_pkg::rsp_t rsp
);
  // The slot store is swept after reset, so nothing is taken right away.
  a_reset_sweep: assert property (@(posedge clk) rst |=> req_stall && !rsp_valid)
    else $error("request taken or response shown during reset sweep");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == lpht_pkg::ST_FULL |-> rsp.slot == '0 && rsp.found_value == '0)
    else $error("full response carries a slot or value");

  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == lpht_pkg::ST_MISSING || rsp.status == lpht_pkg::ST_PRESENT)
      |-> rsp.found_value == '0)
    else $error("miss or present response carries a value");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.live_count <= lpht_pkg::CNT_W'(lpht_pkg::DEPTH))
    else $error("live count beyond table depth");
endmodule

bind linear_probe_hash_table_core lpht_chk u_lpht_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
